// ===== rtl/dfrs_pkg.sv =====
// ----------------------------------------------------------------------------
// dfrs_pkg
// Shared widths, codes and cell control type for the deduplicating FIFO.
// ----------------------------------------------------------------------------
package dfrs_pkg;

  localparam int DEPTH   = 16;
  localparam int VAL_W   = 32;
  localparam int TOTAL_W = 36;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int OCC_W   = 5;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 3;

  // Commands; the high command bit alone selects clear.
  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam int               CMD_CLEAR_BIT = 1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_PUSHED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_POPPED   = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTYPOP = 3'd4;
  localparam logic [STAT_W-1:0] ST_CLEARED  = 3'd5;

  typedef logic signed [VAL_W-1:0] value_t;

  typedef struct packed {
    logic shift;  // take the upper neighbor's value
    logic load;   // take the pushed value
    logic held;   // entry lies below the fill count
  } cell_ctrl_t;

endpackage

// ===== rtl/dfrs_cell.sv =====
// ----------------------------------------------------------------------------
// dfrs_cell
// One FIFO entry: holds a value, shifts down on pop, loads on push, and
// compares its value against the incoming push value.
// ----------------------------------------------------------------------------
module dfrs_cell (
  input  logic                clk,
  input  dfrs_pkg::cell_ctrl_t ctrl,
  input  dfrs_pkg::value_t    push_value,
  input  dfrs_pkg::value_t    upper_value,
  output dfrs_pkg::value_t    data,
  output logic                match
);
  import dfrs_pkg::*;

  value_t data_r;
  value_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.load) begin
      data_nxt = push_value;
    end else if (ctrl.shift) begin
      data_nxt = upper_value;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign match = ctrl.held && (data_r == push_value);

endmodule

// ===== rtl/dedup_fifo_with_running_sum_top.sv =====
// ----------------------------------------------------------------------------
// dedup_fifo_with_running_sum_top
// Result timing: each result is registered and is presented in the cycle after
//   its request is accepted. Throughput: one request per cycle while results are
//   taken; the row of entry cells applies each push, pop or clear directly, and
//   its per-entry comparators settle the duplicate check in the accepting cycle.
// Reset (rst_n low, synchronous): FIFO empty, sum zero, unique mode on,
//   no result pending. Entry contents are not cleared.
// ----------------------------------------------------------------------------
module dedup_fifo_with_running_sum_top (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_we,
  input  logic                        cfg_wdata,
  // request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dfrs_pkg::CMD_W-1:0]  in_cmd,
  input  dfrs_pkg::value_t            in_value,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dfrs_pkg::STAT_W-1:0] out_status,
  output dfrs_pkg::value_t            out_pop_value,
  output logic signed [dfrs_pkg::TOTAL_W-1:0] out_total,
  output logic [dfrs_pkg::OCC_W-1:0]  out_occupancy,
  output logic                        out_is_empty,
  output logic                        out_is_full
);
  import dfrs_pkg::*;

  // Architectural state
  logic                      unique_r;
  logic [CNT_W-1:0]          count_r,  count_nxt;
  logic signed [TOTAL_W-1:0] total_r,  total_nxt;

  // Result register
  logic                      out_valid_r;
  logic [STAT_W-1:0]         status_r, status_nxt;
  value_t                    popval_r, popval_nxt;

  // Cell row; the extra slot feeds zero into the top cell on a pop.
  value_t                    cell_data [DEPTH+1];
  logic [DEPTH-1:0]          cell_match;
  cell_ctrl_t                cell_ctrl [DEPTH];

  logic accept;
  logic is_push, is_pop, is_clear;
  logic fifo_full, fifo_empty, dup_hit;
  logic push_do, pop_do;
  logic signed [TOTAL_W-1:0] push_ext, pop_ext;

  // Take a new request whenever the result register is free or draining.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign is_clear = in_cmd[CMD_CLEAR_BIT];
  assign is_push  = (in_cmd == CMD_PUSH);
  assign is_pop   = (in_cmd == CMD_POP);

  assign fifo_full  = (count_r == CNT_W'(DEPTH));
  assign fifo_empty = (count_r == '0);

  // In unique mode, any held cell equal to the push value flags a duplicate.
  assign dup_hit = unique_r && (|cell_match);

  assign push_do = accept && is_push && !fifo_full && !dup_hit;
  assign pop_do  = accept && is_pop && !fifo_empty;

  // Row of entry cells, oldest at index 0.
  assign cell_data[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign cell_ctrl[i].shift = pop_do;
    assign cell_ctrl[i].load  = push_do && (count_r == CNT_W'(i));
    assign cell_ctrl[i].held  = (CNT_W'(i) < count_r);

    dfrs_cell u_cell (
      .clk         (clk),
      .ctrl        (cell_ctrl[i]),
      .push_value  (in_value),
      .upper_value (cell_data[i+1]),
      .data        (cell_data[i]),
      .match       (cell_match[i])
    );
  end

  // Sign-extend push and pop values to the sum width.
  assign push_ext = {{(TOTAL_W-VAL_W){in_value[VAL_W-1]}}, in_value};
  assign pop_ext  = {{(TOTAL_W-VAL_W){cell_data[0][VAL_W-1]}}, cell_data[0]};

  // Decide status, count and sum for this request.
  always_comb begin
    count_nxt  = count_r;
    total_nxt  = total_r;
    status_nxt = status_r;
    popval_nxt = popval_r;
    if (accept) begin
      popval_nxt = '0;
      if (is_clear) begin
        count_nxt  = '0;
        total_nxt  = '0;
        status_nxt = ST_CLEARED;
      end else if (is_push) begin
        if (fifo_full) begin
          status_nxt = ST_FULL;
        end else if (dup_hit) begin
          status_nxt = ST_DUP;
        end else begin
          count_nxt  = count_r + CNT_W'(1);
          total_nxt  = total_r + push_ext;
          status_nxt = ST_PUSHED;
        end
      end else begin
        if (fifo_empty) begin
          status_nxt = ST_EMPTYPOP;
        end else begin
          count_nxt  = count_r - CNT_W'(1);
          total_nxt  = total_r - pop_ext;
          popval_nxt = cell_data[0];
          status_nxt = ST_POPPED;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unique_r    <= 1'b1;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique_r <= cfg_wdata;
      end
      count_r <= count_nxt;
      total_r <= total_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; the count and sum registers already hold post-request values.
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    popval_r <= popval_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_pop_value = popval_r;
  assign out_total     = total_r;
  assign out_occupancy = OCC_W'(count_r);
  assign out_is_empty  = (count_r == '0);
  assign out_is_full   = (count_r == CNT_W'(DEPTH));

endmodule
